### rtl/swst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_pkg: shared types and constants for sliding window statistics
// Sizes, queue entry and result records, back end state encoding.
// ----------------------------------------------------------------------------
package swst_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int LEN_W   = 7;                             // window_length register
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W   = (LEN_W > FILL_W) ? LEN_W : FILL_W;
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(SUM_W + 1);
    localparam int TOTAL_W = 32;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;
    localparam logic [LEN_W-1:0] WIN_LEN_RESET = LEN_W'(16);
    localparam logic [PADDR_W-3:0] REG_WIN_LEN = '0;        // word index of window_length

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // one classified sample waiting for the back end
    typedef struct packed {
        t_sample             sample;
        logic [PTR_W-1:0]    ptr;
        logic [FILL_W-1:0]   fill;
        logic [TOTAL_W-1:0]  total;
    } t_job;

    typedef struct packed {
        t_sample                   latest;
        t_sample                   window_min;
        t_sample                   window_max;
        logic [SAMPLE_BITS-1:0]    spread;
        t_sample                   mean;
        logic [FILL_W-1:0]         fill_count;
        logic [TOTAL_W-1:0]        total_count;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_HOLD
    } t_back_state;

endpackage
`default_nettype wire

### rtl/swst_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_front: input beat acceptance and bookkeeping
// Tracks ring write pointer, window fill and saturating total per sample.
// ----------------------------------------------------------------------------
module swst_front
    import swst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [LEN_W-1:0]  i_win_len,
    input  wire logic              i_valid,
    input  wire t_sample           i_sample,
    output logic                   o_ready,
    output logic                   o_push,
    output t_job                   o_job,
    input  wire logic              i_full
);

    logic [PTR_W-1:0]   r_wptr,  n_wptr;
    logic [FILL_W-1:0]  r_fill,  n_fill;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [FILL_W-1:0]  eff_len;
    logic [CMP_W-1:0]   len_x;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // zero length acts as one, oversize saturates
    always_comb begin
        len_x = CMP_W'(i_win_len);
        if (i_win_len == '0) begin
            eff_len = FILL_W'(1);
        end else if (len_x > CMP_W'(MAX_WINDOW)) begin
            eff_len = FILL_W'(MAX_WINDOW);
        end else begin
            eff_len = FILL_W'(len_x);
        end
    end

    always_comb begin
        n_wptr  = (r_wptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wptr + PTR_W'(1);
        n_fill  = (({1'b0, r_fill} + (FILL_W+1)'(1)) < {1'b0, eff_len})
                  ? r_fill + FILL_W'(1) : eff_len;
        n_total = (r_total == '1) ? r_total : r_total + TOTAL_W'(1);
    end

    always_comb begin
        o_job.sample = i_sample;
        o_job.ptr    = r_wptr;
        o_job.fill   = n_fill;
        o_job.total  = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else if (o_push) begin
            r_wptr  <= n_wptr;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

endmodule
`default_nettype wire

### rtl/swst_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_queue: short job queue between front and back end
// Two-entry FIFO so the front keeps taking beats while the back end works.
// ----------------------------------------------------------------------------
module swst_queue
    import swst_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_job       o_job
);

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/swst_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_back: sample ring, window scan, mean divider and result register
// Writes the sample, scans fill entries one per cycle, divides bit-serially.
// ----------------------------------------------------------------------------
module swst_back
    import swst_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_job  i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_res
);

    t_back_state r_state, n_state;

    t_sample                  r_mem [MAX_WINDOW];
    t_sample                  r_rdata;
    logic                     r_rvld;
    logic [PTR_W-1:0]         r_addr;
    logic [FILL_W-1:0]        r_left;

    t_sample                  r_sample;
    logic [FILL_W-1:0]        r_fill;
    logic [TOTAL_W-1:0]       r_total;
    t_sample                  r_lo;
    t_sample                  r_hi;
    logic signed [SUM_W-1:0]  r_sum;

    logic                     r_neg;
    logic [SUM_W-1:0]         r_quo;
    logic [FILL_W-1:0]        r_rem;
    logic [CNT_W-1:0]         r_cnt;

    logic                     r_o_valid;
    t_result                  r_res;

    logic                     rd_en;
    logic                     div_load;
    logic                     div_step;
    logic                     out_load;
    logic                     out_free;

    logic [FILL_W:0]          rem_sh;
    logic                     rem_ge;
    logic [SUM_W-1:0]         quo_signed;
    logic [SAMPLE_BITS-1:0]   spread;

    assign out_free = !r_o_valid || i_ready;
    assign o_valid  = r_o_valid;
    assign o_res    = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_left == '0 && !r_rvld) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(1)) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        div_load = 1'b0;
        div_step = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: o_pop    = !i_empty;
            S_SCAN: begin
                rd_en    = (r_left != '0);
                div_load = (r_left == '0) && !r_rvld;
            end
            S_DIV:  div_step = 1'b1;
            S_HOLD: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[i_job.ptr] <= i_job.sample;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_comb begin
        rem_sh     = {r_rem, r_quo[SUM_W-1]};
        rem_ge     = (rem_sh >= {1'b0, r_fill});
        quo_signed = r_neg ? (-r_quo) : r_quo;
        spread     = SAMPLE_BITS'(r_hi - r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= i_job.sample;
            r_fill   <= i_job.fill;
            r_total  <= i_job.total;
            r_lo     <= i_job.sample;
            r_hi     <= i_job.sample;
            r_sum    <= '0;
            r_addr   <= i_job.ptr;
            r_left   <= i_job.fill;
        end else begin
            if (rd_en) begin
                r_addr <= (r_addr == '0) ? PTR_W'(MAX_WINDOW - 1) : r_addr - PTR_W'(1);
                r_left <= r_left - FILL_W'(1);
            end
            if (r_rvld) begin
                if (r_rdata < r_lo) r_lo <= r_rdata;
                if (r_rdata > r_hi) r_hi <= r_rdata;
                r_sum <= r_sum + SUM_W'(r_rdata);
            end
        end
    end

    // restoring divide of |sum| by fill, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_rem <= '0;
            r_cnt <= CNT_W'(SUM_W);
        end else if (div_step) begin
            r_rem <= rem_ge ? FILL_W'(rem_sh - {1'b0, r_fill}) : FILL_W'(rem_sh);
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res.latest      <= r_sample;
            r_res.window_min  <= r_lo;
            r_res.window_max  <= r_hi;
            r_res.spread      <= spread;
            r_res.mean        <= t_sample'(quo_signed[SAMPLE_BITS-1:0]);
            r_res.fill_count  <= r_fill;
            r_res.total_count <= r_total;
        end
    end

endmodule
`default_nettype wire

### rtl/sliding_window_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_statistics_top: windowed min/max/mean over Q8.8 samples
// Input channel i_valid/o_ready carries one signed Q8.8 sample per beat.
// Output channel o_valid/i_ready returns one result beat per sample: the
// sample, window min, max, spread, truncated mean, fill and total count.
// window_length sits at APB byte address 0 (reset 16); write it only while
// no sample is in flight. Zero acts as one, values above 64 saturate.
//
// A sample's result follows these steps after the back end pops it: the pop
// and ring write, F ring reads for a fill of F (one read port, one entry
// per cycle), folding in the last read and loading the divider, bit-serial
// division for the mean, and loading the result register. The back end
// handles one sample at a time and pops the next only once the result
// register has taken the last one.
// The front end takes beats into a two-entry queue, so up to two samples
// are accepted while the back end is busy or the receiver stalls; a held
// result simply waits in the output register until i_ready.
// Reset clears pointer, fill, total count, queue and output valid; the
// ring is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module sliding_window_statistics_top
    import swst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // APB configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready,
    // sample input
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    // result output
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_latest,
    output logic signed [SAMPLE_BITS-1:0] o_window_min,
    output logic signed [SAMPLE_BITS-1:0] o_window_max,
    output logic [SAMPLE_BITS-1:0]       o_spread,
    output logic signed [SAMPLE_BITS-1:0] o_mean,
    output logic [FILL_W-1:0]            o_fill_count,
    output logic [TOTAL_W-1:0]           o_total_count
);

    logic [LEN_W-1:0] r_win_len;
    logic             sel_len;
    logic             cfg_wr;

    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    t_job    front_job;
    t_job    q_job;
    t_result res;

    // register decode on word index, low byte bits ignored
    assign pready  = 1'b1;
    assign sel_len = (paddr[PADDR_W-1:2] == REG_WIN_LEN);
    assign cfg_wr  = psel && penable && pwrite && pready && sel_len;
    assign prdata  = sel_len ? PDATA_W'(r_win_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RESET;
        end else if (cfg_wr) begin
            r_win_len <= pwdata[LEN_W-1:0];
        end
    end

    swst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win_len (r_win_len),
        .i_valid   (i_valid),
        .i_sample  (i_sample),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_job     (front_job),
        .i_full    (q_full)
    );

    swst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    swst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_latest      = res.latest;
    assign o_window_min  = res.window_min;
    assign o_window_max  = res.window_max;
    assign o_spread      = res.spread;
    assign o_mean        = res.mean;
    assign o_fill_count  = res.fill_count;
    assign o_total_count = res.total_count;

endmodule
`default_nettype wire

### rtl/swst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swst_checker: port-level checks on the result channel
// Held beats, window fill range and min/max/spread consistency.
// ----------------------------------------------------------------------------
module swst_checker
    import swst_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_valid,
    input  wire logic                          i_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] o_latest,
    input  wire logic signed [SAMPLE_BITS-1:0] o_window_min,
    input  wire logic signed [SAMPLE_BITS-1:0] o_window_max,
    input  wire logic [SAMPLE_BITS-1:0]        o_spread,
    input  wire logic [FILL_W-1:0]             o_fill_count
);

    // a stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_latest) && $stable(o_window_min)
            && $stable(o_window_max) && $stable(o_fill_count))
        else $error("result beat changed while stalled");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fill_count != '0) && (o_fill_count <= FILL_W'(MAX_WINDOW)))
        else $error("fill count out of range");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_window_min <= o_latest) && (o_latest <= o_window_max))
        else $error("latest sample outside window min/max");

    a_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_spread == SAMPLE_BITS'(o_window_max - o_window_min))
        else $error("spread does not match max minus min");

endmodule

bind sliding_window_statistics_top swst_checker u_swst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_latest     (o_latest),
    .o_window_min (o_window_min),
    .o_window_max (o_window_max),
    .o_spread     (o_spread),
    .o_fill_count (o_fill_count)
);
`default_nettype wire

### test/sliding_window_statistics_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_statistics_top_tb: self-checking bench for window statistics
// Streams Q8.8 samples through the block under a range of window lengths set
// over APB, predicts each result beat in a scoreboard and compares every
// field. Both channels idle at random; one phase stalls the output for a long
// stretch so the input side backs up.
// ----------------------------------------------------------------------------
module sliding_window_statistics_top_tb
    import swst_pkg::*;
();

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int IDLE_PCT      = 15;
    localparam int HOLD_CYCLES   = 400;    // long output stall
    localparam int STALL_LIMIT   = 5000;   // cycles with no beat at all
    localparam int DRAIN_CYCLES  = 120;    // outlasts one full-window sample
    localparam int CALM_PHASE    = 4;      // no idling on either side
    localparam int PRESSURE_PHASE = 7;
    localparam logic [PADDR_W-3:0] REG_UNUSED = REG_WIN_LEN + 1'b1;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of ring, pointer, fill, total and window length
    // ------------------------------------------------------------------
    class window_stats_scoreboard;
        t_sample            ring[MAX_WINDOW];
        int unsigned        wr_ptr;
        int unsigned        fill;
        logic [TOTAL_W-1:0] total;
        logic [LEN_W-1:0]   win_len;
        t_result            expected_results[$];
        int unsigned        mismatches;
        int unsigned        results_checked;

        function new();
            wr_ptr          = 0;
            fill            = 0;
            total           = '0;
            win_len         = WIN_LEN_RESET;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void compare_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t mismatch %s (beat %0d): expected %0d, got %0d",
                             $realtime, name, results_checked, exp_v, got_v);
            end
        endfunction

        // accepted input beat: work out the result it must cause
        function void note_sample(t_sample smp);
            int unsigned eff;
            int unsigned pos;
            t_sample     lo;
            t_sample     hi;
            longint      sum;
            t_result     r;
            // zero acts as one, anything above the ring size saturates
            if (win_len == 0)
                eff = 1;
            else if (win_len > MAX_WINDOW)
                eff = MAX_WINDOW;
            else
                eff = win_len;
            ring[wr_ptr] = smp;
            wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
            // a shrunk window drops straight to the new length
            fill = (fill + 1 < eff) ? fill + 1 : eff;
            if (total != '1)
                total++;
            lo  = smp;
            hi  = smp;
            sum = 0;
            pos = wr_ptr;
            for (int i = 0; i < fill; i++) begin
                pos = (pos == 0) ? MAX_WINDOW - 1 : pos - 1;
                if (ring[pos] < lo) lo = ring[pos];
                if (ring[pos] > hi) hi = ring[pos];
                sum += ring[pos];
            end
            r.latest      = smp;
            r.window_min  = lo;
            r.window_max  = hi;
            r.spread      = SAMPLE_BITS'(longint'(hi) - longint'(lo));
            r.mean        = t_sample'(sum / longint'(fill));   // truncates toward zero
            r.fill_count  = FILL_W'(fill);
            r.total_count = total;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result beat with nothing pending: latest %0d",
                             $realtime, got.latest);
                return;
            end
            e = expected_results[0];
            expected_results.delete(0);
            compare_field("latest",      e.latest,      got.latest);
            compare_field("window_min",  e.window_min,  got.window_min);
            compare_field("window_max",  e.window_max,  got.window_max);
            compare_field("spread",      e.spread,      got.spread);
            compare_field("mean",        e.mean,        got.mean);
            compare_field("fill_count",  e.fill_count,  got.fill_count);
            compare_field("total_count", e.total_count, got.total_count);
            results_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [PADDR_W-1:0]      paddr   = '0;
    logic [PDATA_W-1:0]      pwdata  = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    i_valid  = 1'b0;
    logic                    o_ready;
    t_sample                 i_sample = '0;
    logic                    o_valid;
    logic                    i_ready  = 1'b0;
    t_sample                 o_latest;
    t_sample                 o_window_min;
    t_sample                 o_window_max;
    logic [SAMPLE_BITS-1:0]  o_spread;
    t_sample                 o_mean;
    logic [FILL_W-1:0]       o_fill_count;
    logic [TOTAL_W-1:0]      o_total_count;

    window_stats_scoreboard sb = new();

    // knobs shared by the sender, receiver and main sequence
    bit          calm     = 1'b0;   // suppress random idling
    bit          hold_req = 1'b0;   // ask the receiver for one long stall
    int unsigned samples_sent     = 0;
    int unsigned settings_written = 0;
    t_result     observed;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    sliding_window_statistics_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_latest      (o_latest),
        .o_window_min  (o_window_min),
        .o_window_max  (o_window_max),
        .o_spread      (o_spread),
        .o_mean        (o_mean),
        .o_fill_count  (o_fill_count),
        .o_total_count (o_total_count)
    );

    // ------------------------------------------------------------------
    // Receiver: random i_ready at the falling edge; one long hold on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // stall the output while the sender keeps offering beats,
                // so the input queue fills and o_ready drops
                hold_req = 1'b0;
                i_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready = calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result monitor: sample at the rising edge, before the DUT updates
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            observed.latest      = o_latest;
            observed.window_min  = o_window_min;
            observed.window_max  = o_window_max;
            observed.spread      = o_spread;
            observed.mean        = o_mean;
            observed.fill_count  = o_fill_count;
            observed.total_count = o_total_count;
            sb.check_result(observed);
        end
    end

    // Watchdog: cycles in a row with no beat on any port
    initial begin
        int unsigned quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles, %0d results pending",
                 STALL_LIMIT, sb.expected_results.size());
        $display("[sliding_window_statistics_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver tasks; all drive at the falling edge
    // ------------------------------------------------------------------

    // one input beat; returns at the rising edge that accepted it
    task automatic send_sample(input t_sample smp);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_sample = smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(smp);
        samples_sent++;
    endtask

    // drop valid and wait until every expected beat has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-3:0] idx, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);                    // pready is tied high
        if (idx == REG_WIN_LEN) begin
            sb.win_len = data[LEN_W-1:0];
            settings_written++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_window_length();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {REG_WIN_LEN, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        sb.compare_field("window_length readback", sb.win_len, prdata[LEN_W-1:0]);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // window length for a random phase: extremes often, short windows mostly
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(7))
            0:       return '0;                                  // acts as one
            1:       return LEN_W'(1);
            2:       return LEN_W'(MAX_WINDOW + 1 + $urandom_range(62)); // saturates
            3:       return LEN_W'(MAX_WINDOW);
            4:       return LEN_W'($urandom_range(MAX_WINDOW));
            default: return LEN_W'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic t_sample pick_sample(t_sample prev);
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return t_sample'(int'($urandom_range(511)) - 256); // near zero
            3:       return prev;                                       // flat run
            default: return t_sample'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_sample     first_run[8];
        t_sample     shrink_run[3];
        t_sample     smp;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned random_sent;

        first_run  = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1,
                       16'sd1, 16'sh5555, 16'shAAAA, 16'sh0100};
        shrink_run = '{16'sh8000, 16'sh7FFF, -16'sd1};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset length, full-scale spread, mean rounding of
        // negative sums
        check_window_length();
        foreach (first_run[k]) send_sample(first_run[k]);
        drain();

        // zero length acts as one; fill collapses from eight at once
        apb_write(REG_WIN_LEN, '0);
        foreach (shrink_run[k]) send_sample(shrink_run[k]);
        drain();

        // writes to an unmapped word are ignored; upper data bits are dropped
        apb_write(REG_UNUSED, 32'd3);
        check_window_length();
        apb_write(REG_WIN_LEN, 32'hFFFF_FF85);
        check_window_length();
        for (int k = 0; k < 4; k++) send_sample(t_sample'(-16'sd300 * k));
        drain();

        // largest code saturates to the ring size; window then grows by one
        apb_write(REG_WIN_LEN, 32'h7F);
        check_window_length();
        for (int k = 0; k < 6; k++) send_sample(k[0] ? 16'sh7FFF : 16'sh8001);
        drain();

        // random phases: new window length, then a run of samples
        random_sent = 0;
        phase       = 0;
        smp         = '0;
        while (random_sent < RANDOM_ITEMS) begin
            apb_write(REG_WIN_LEN, ($urandom() << LEN_W) | pick_length());
            if ($urandom_range(9) == 0)
                apb_write(REG_UNUSED, $urandom());
            check_window_length();
            phase_len = (phase == PRESSURE_PHASE) ? 40 : $urandom_range(10, 90);
            for (int n = 0; n < phase_len; n++) begin
                smp = pick_sample(smp);
                send_sample(smp);
                random_sent++;
                // flags change at a rising edge so the receiver sees them
                // cleanly at the next falling edge
                if (n == 0)
                    calm = (phase == CALM_PHASE);
                if (n == 2 && phase == PRESSURE_PHASE)
                    hold_req = 1'b1;
            end
            drain();
            phase++;
        end

        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples over %0d window settings, %0d result beats checked",
                 samples_sent, settings_written, sb.results_checked);
        $display("mismatches %0d, results still pending %0d",
                 sb.mismatches, sb.expected_results.size());
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("[sliding_window_statistics_top] OK");
        end else begin
            $display("[sliding_window_statistics_top] ERROR");
        end
        $finish;
    end

endmodule
